@@ rtl/core/mpq_string_hash_defines.svh @@
// Assertion macros for the string hash block.
`ifndef MPQ_STRING_HASH_DEFINES_SVH
`define MPQ_STRING_HASH_DEFINES_SVH

`ifndef SYNTHESIS

// Checked on every rising clock edge outside reset.
`define MSH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("mpq_string_hash: check failed");

// Checked on every rising clock edge, reset included.
`define MSH_ASSERT_RST(lbl, prop) \
    lbl: assert property (@(posedge i_clk) (prop)) \
        else $error("mpq_string_hash: reset check failed");

`else

`define MSH_ASSERT(lbl, prop)
`define MSH_ASSERT_RST(lbl, prop)

`endif

`endif

@@ rtl/core/msh_pkg.sv @@
package msh_pkg;

    localparam int TABLE_TYPES_DEF = 5;
    localparam int SLICE_WORDS     = 256;
    localparam int CHAR_W          = 8;
    localparam int WORD_W          = 32;

    // generator: g = (g * 125 + 3) mod 0x2AAAAB
    localparam int GEN_W = 22;
    localparam logic [GEN_W-1:0] GEN_START = 22'h100001;
    localparam logic [GEN_W-1:0] GEN_MOD   = 22'h2AAAAB;
    localparam logic [6:0]       GEN_MUL   = 7'd125;
    localparam logic [1:0]       GEN_ADD   = 2'd3;
    // 3 * GEN_MOD = 2^23 + 1, so the reduction runs modulo 2^23 + 1
    localparam int RED_W = 23;
    localparam logic [RED_W:0]   RED_MOD   = 24'h800001;
    // inverse of 3 modulo 2^23
    localparam logic [RED_W-1:0] INV3      = 23'h2AAAAB;

    localparam logic [WORD_W-1:0] SEED_A_START = 32'h7FED7FED;
    localparam logic [WORD_W-1:0] SEED_B_START = 32'hEEEEEEEE;
    localparam logic [WORD_W-1:0] SEED_B_ADD   = 32'd3;

    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET  = 8'h20;

    // configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int HTYPE_W    = 3;
    localparam logic [CFG_ADDR_W-3:0] REG_HASH_TYPE = 1'b0;
    localparam logic [CFG_ADDR_W-3:0] REG_FOLD_CASE = 1'b1;
    localparam logic [HTYPE_W-1:0]    HTYPE_RESET   = 3'd0;

    typedef enum logic [2:0] {
        FILL_MUL  = 3'b001,
        FILL_RED  = 3'b010,
        FILL_DONE = 3'b100
    } t_fill_state;

endpackage

@@ rtl/core/mpq_string_hash.sv @@
// MPQ file-name hash, one character byte per item. After reset the block
// builds its crypt table of 256 * TABLE_TYPES words from a congruential
// generator; each generator output passes the FILL_MUL and FILL_RED states
// and each word needs two outputs, and o_s_tready stays low until the fill
// ends. After that the block takes one character per cycle while no last
// character is held in the read stage: the table is read into r_rdata when
// an item is accepted and the seeds are updated when it leaves the read
// stage, which for a last character also loads the output register that
// drives o_m_tvalid. A last character waits in the read stage while
// the output register is full, and that holds off the input. tuser marks the
// first character of a string (seeds are reloaded), tlast the last one (both
// seeds are emitted). Seeds are not reloaded after a result by themselves,
// and empty strings are not supported.
`include "mpq_string_hash_defines.svh"

module mpq_string_hash
    import msh_pkg::*;
#(
    parameter int TABLE_TYPES = TABLE_TYPES_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input items
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [CHAR_W-1:0]     i_s_tdata,   // [7:0] char_code
    input  logic                  i_s_tuser,   // [0] first_of_string
    input  logic                  i_s_tlast,   // last_of_string
    // result items
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [2*WORD_W-1:0]   o_m_tdata,   // [31:0] hash_value, [63:32] second_value
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int TABLE_WORDS = TABLE_TYPES * SLICE_WORDS;
    localparam int TAB_AW      = $clog2(TABLE_WORDS);
    localparam int TYPE_W      = (TABLE_TYPES > 1) ? $clog2(TABLE_TYPES) : 1;
    localparam int SLICE_AW    = $clog2(SLICE_WORDS);
    localparam int HALF_W      = WORD_W / 2;

    // ---------------- configuration ----------------
    logic [HTYPE_W-1:0]    r_hash_type;
    logic                  r_fold_case;
    logic                  cfg_wr;
    logic [CFG_ADDR_W-3:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[CFG_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash_type <= HTYPE_RESET;
            r_fold_case <= 1'b1;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_HASH_TYPE: r_hash_type <= pwdata[HTYPE_W-1:0];
                REG_FOLD_CASE: r_fold_case <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_HASH_TYPE: prdata = CFG_DATA_W'(r_hash_type);
            REG_FOLD_CASE: prdata = CFG_DATA_W'(r_fold_case);
            default:       prdata = '0;
        endcase
    end

    // ---------------- table fill ----------------
    t_fill_state         r_fill_state;
    logic [GEN_W-1:0]    r_gen;
    logic [RED_W-1:0]    r_red;
    logic                r_half;
    logic [HALF_W-1:0]   r_hi;
    logic [SLICE_AW-1:0] r_fill_k;
    logic [TYPE_W-1:0]   r_fill_j;

    logic [28:0]         gen_x;
    logic [30:0]         gen_x3;
    logic [RED_W:0]      gen_diff;
    logic [RED_W:0]      gen_fold;
    logic [RED_W-1:0]    gen_prod;
    logic [GEN_W-1:0]    gen_next;
    logic                fill_we;
    logic [TAB_AW-1:0]   fill_addr;
    logic                fill_done;

    always_comb begin
        gen_x    = 29'(r_gen) * 29'(GEN_MUL) + 29'(GEN_ADD);
        gen_x3   = 31'(gen_x) * 31'd3;
        // 2^23 == -1 modulo 2^23 + 1
        gen_diff = {1'b0, gen_x3[RED_W-1:0]} - (RED_W+1)'(gen_x3[30:RED_W]);
        gen_fold = gen_diff[RED_W] ? gen_diff + RED_MOD : gen_diff;
        // r_red is an exact multiple of 3
        gen_prod = r_red * INV3;
        gen_next = gen_prod[GEN_W-1:0];
    end

    assign fill_done = (r_fill_state == FILL_DONE);
    assign fill_we   = (r_fill_state == FILL_RED) && r_half;
    assign fill_addr = TAB_AW'({r_fill_j, r_fill_k});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill_state <= FILL_MUL;
            r_gen        <= GEN_START;
            r_half       <= 1'b0;
            r_fill_k     <= '0;
            r_fill_j     <= '0;
        end else begin
            case (r_fill_state)
                FILL_MUL: begin
                    r_fill_state <= FILL_RED;
                end
                FILL_RED: begin
                    r_gen  <= gen_next;
                    r_half <= !r_half;
                    r_fill_state <= FILL_MUL;
                    if (r_half) begin
                        if (r_fill_j == TYPE_W'(TABLE_TYPES - 1)) begin
                            r_fill_j <= '0;
                            r_fill_k <= r_fill_k + 1'b1;
                            if (&r_fill_k)
                                r_fill_state <= FILL_DONE;
                        end else begin
                            r_fill_j <= r_fill_j + 1'b1;
                        end
                    end
                end
                FILL_DONE: ;
                default: r_fill_state <= FILL_MUL;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_fill_state == FILL_MUL)
            r_red <= gen_fold[RED_W-1:0];
        if (r_fill_state == FILL_RED && !r_half)
            r_hi <= gen_next[HALF_W-1:0];
    end

    // ---------------- input stage: fold and table read ----------------
    logic                r_s1_valid;
    logic                r_s1_first;
    logic                r_s1_last;
    logic [CHAR_W-1:0]   r_s1_char;
    logic [WORD_W-1:0]   r_rdata;
    logic [WORD_W-1:0]   r_table [TABLE_WORDS];

    logic                r_o_valid;
    logic [2*WORD_W-1:0] r_o_data;

    logic                in_acc;
    logic                s1_adv;
    logic                out_free;
    logic [CHAR_W-1:0]   ch_fold;
    logic [HTYPE_W-1:0]  type_sat;
    logic [TAB_AW-1:0]   rd_addr;

    assign out_free   = !r_o_valid || i_m_tready;
    assign s1_adv     = r_s1_valid && (!r_s1_last || out_free);
    assign o_s_tready = fill_done && (!r_s1_valid || s1_adv);
    assign in_acc     = i_s_tvalid && o_s_tready;

    always_comb begin
        if (r_fold_case && i_s_tdata >= CHAR_LOWER_A && i_s_tdata <= CHAR_LOWER_Z)
            ch_fold = i_s_tdata - CASE_OFFSET;
        else
            ch_fold = i_s_tdata;
        if (r_hash_type >= HTYPE_W'(TABLE_TYPES))
            type_sat = HTYPE_W'(TABLE_TYPES - 1);
        else
            type_sat = r_hash_type;
        rd_addr = TAB_AW'({type_sat, ch_fold});
    end

    always_ff @(posedge i_clk) begin
        if (fill_we)
            r_table[fill_addr] <= {r_hi, gen_next[HALF_W-1:0]};
        if (in_acc)
            r_rdata <= r_table[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (in_acc)
            r_s1_valid <= 1'b1;
        else if (s1_adv)
            r_s1_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_char  <= ch_fold;
            r_s1_first <= i_s_tuser;
            r_s1_last  <= i_s_tlast;
        end
    end

    // ---------------- seed update ----------------
    logic [WORD_W-1:0] r_seed_a;
    logic [WORD_W-1:0] r_seed_b;
    logic [WORD_W-1:0] seed_a_in;
    logic [WORD_W-1:0] seed_b_in;
    logic [WORD_W-1:0] n_seed_a;
    logic [WORD_W-1:0] n_seed_b;

    always_comb begin
        seed_a_in = r_s1_first ? SEED_A_START : r_seed_a;
        seed_b_in = r_s1_first ? SEED_B_START : r_seed_b;
        n_seed_a  = r_rdata ^ (seed_a_in + seed_b_in);
        n_seed_b  = WORD_W'(r_s1_char) + n_seed_a + seed_b_in + (seed_b_in << 5)
                    + SEED_B_ADD;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_a <= SEED_A_START;
            r_seed_b <= SEED_B_START;
        end else if (s1_adv) begin
            r_seed_a <= n_seed_a;
            r_seed_b <= n_seed_b;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_o_valid <= 1'b0;
        else if (s1_adv && r_s1_last)
            r_o_valid <= 1'b1;
        else if (i_m_tready)
            r_o_valid <= 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last)
            r_o_data <= {n_seed_b, n_seed_a};
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_data;

    // ---------------- checks ----------------
    `MSH_ASSERT(a_idle_during_fill, !fill_done |-> (!o_s_tready && !r_s1_valid && !r_o_valid))
    `MSH_ASSERT(a_gen_in_range, r_gen < GEN_MOD)
    `MSH_ASSERT(a_result_from_last, $rose(r_o_valid) |-> $past(r_s1_valid && r_s1_last))
    `MSH_ASSERT(a_stall_keeps_read, (r_s1_valid && !s1_adv) |=> (r_s1_valid && $stable(r_rdata)))
    `MSH_ASSERT_RST(a_reset_clears, !i_rst_n |=> (!r_o_valid && !r_s1_valid))

endmodule
